// File: sv/cfls_pkg.sv
// Package for the credit fair link scheduler: command and status codes,
// register addresses, request/result payload and link table entry structs. No dependencies.
package cfls_pkg;

  localparam logic [2:0] CMD_LINK_UP   = 3'd0;
  localparam logic [2:0] CMD_LINK_DOWN = 3'd1;
  localparam logic [2:0] CMD_ENQUEUE   = 3'd2;
  localparam logic [2:0] CMD_ISSUE     = 3'd3;
  localparam logic [2:0] CMD_COMPLETED = 3'd4;
  localparam logic [2:0] CMD_SET_PARK  = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NO_LINKS  = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOW = 3'd4;
  localparam logic [2:0] ST_NO_CREDIT = 3'd5;
  localparam logic [2:0] ST_REFUSED   = 3'd6;

  localparam logic [0:0] REG_BUFFERS   = 1'd0;
  localparam logic [0:0] REG_BROADCAST = 1'd1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] handle;
    logic        parked;
    logic [7:0]  count;
    logic        link_accepts;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        sent;
    logic [11:0] send_handle;
    logic [7:0]  credits;
  } rsp_t;

  typedef struct packed {
    logic [11:0] handle;
    logic [7:0]  queued;
    logic [7:0]  in_flight;
    logic        parked;
  } entry_t;

endpackage

// File: sv/credit_fair_link_scheduler.sv
// Credit fair link scheduler: link table in one synchronous memory, walked
// by a sequencer one entry per cycle. Depends on cfls_pkg.
//
// Link down does a full search and then compacts the table, reading each later
// entry and writing it one slot down. Issue next with nothing queued fetches
// entry 0 as an extra step.
// busy is high from acceptance until the strobe; the next request can be
// accepted at the edge that ends the strobe. The result cannot be stalled.
// Reset (rst, synchronous) empties the table, clears credits in use and
// the last sender, and loads controller_buffers=8, broadcast_handle=0.
module credit_fair_link_scheduler #(
  parameter int MAX_LINKS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cfls_pkg::req_t    req,
  output logic              done,
  output cfls_pkg::rsp_t    rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import cfls_pkg::*;

  localparam int IW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int CW = $clog2(MAX_LINKS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FETCH, S_ACT, S_SHIFT, S_DONE
  } state_t;

  // Link table: one entry per link, registered read.
  entry_t mem [MAX_LINKS];
  entry_t rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Configuration registers.
  logic [7:0]  controller_buffers;
  logic [11:0] broadcast_handle;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      controller_buffers <= 8'd8;
      broadcast_handle   <= 12'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_BROADCAST: broadcast_handle   <= pwdata[11:0];
        default:       controller_buffers <= pwdata[7:0];
      endcase
    end
  end
  always_comb begin
    case (paddr[2])
      REG_BROADCAST: prdata = {20'd0, broadcast_handle};
      default:       prdata = {24'd0, controller_buffers};
    endcase
  end

  state_t        state;
  req_t          cur;
  logic [CW-1:0] link_total;
  logic [IW-1:0] last_sender;
  logic [7:0]    outstanding;
  logic [CW-1:0] k;        // entries issued to the read port
  logic [IW-1:0] idx;      // entry whose data returns this cycle
  logic          rvalid;
  logic          have;
  logic [IW-1:0] best;
  entry_t        best_e;
  logic [IW-1:0] shift_i;

  // Next scan address, circular over the table.
  logic [IW-1:0] scan_addr;
  logic [IW-1:0] scan_first;
  always_comb begin
    if (CW'(last_sender) + CW'(1) >= link_total || link_total <= CW'(1))
      scan_first = '0;
    else
      scan_first = last_sender + IW'(1);
  end

  logic [7:0] free;
  assign free = (controller_buffers > outstanding) ? controller_buffers - outstanding : 8'd0;

  logic is_scan;
  assign is_scan = (cur.cmd == CMD_ISSUE);

  // Candidate test for returning data.
  logic hit;
  always_comb begin
    if (is_scan)
      hit = (rd_data.queued != 8'd0) && (!have || rd_data.in_flight < best_e.in_flight);
    else
      hit = !have && (rd_data.handle == cur.handle);
  end

  logic [IW-1:0] nxt_wrap;
  assign nxt_wrap = (CW'(scan_addr) + CW'(1) >= link_total) ? '0
                    : scan_addr + IW'(1);

  always_comb begin
    rd_addr = scan_addr;
    if (state == S_FETCH || state == S_SHIFT) rd_addr = shift_i;
    if (state == S_SHIFT) rd_addr = shift_i + IW'(1);
  end

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    done  <= 1'b0;
    if (rst) begin
      state       <= S_IDLE;
      busy        <= 1'b0;
      link_total  <= '0;
      last_sender <= '0;
      outstanding <= '0;
      rvalid      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cur    <= req;
            busy   <= 1'b1;
            have   <= 1'b0;
            best   <= '0;
            k      <= '0;
            rvalid <= 1'b0;
            scan_addr <= (req.cmd == CMD_ISSUE) ? scan_first : '0;
            rsp    <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // One read issued and one compared per cycle.
          rvalid <= (k < link_total);
          idx    <= scan_addr;
          if (k < link_total) begin
            k         <= k + CW'(1);
            scan_addr <= nxt_wrap;
          end
          if (rvalid && hit) begin
            have   <= 1'b1;
            best   <= idx;
            best_e <= rd_data;
          end
          if (k == link_total && !rvalid) begin
            shift_i <= best;
            state   <= (is_scan && !have) ? S_FETCH : S_ACT;
          end
        end
        S_FETCH: begin
          // No queued link: entry 0 is the pick.
          shift_i <= '0;
          best    <= '0;
          state   <= S_ACT;
        end
        S_ACT: begin
          if (is_scan && !have) best_e <= rd_data;
          state <= S_DONE;
          case (cur.cmd)
            CMD_LINK_UP: begin
              if (link_total >= CW'(MAX_LINKS)) rsp.status <= ST_FULL;
              else begin
                wr_en   <= 1'b1;
                wr_addr <= link_total[IW-1:0];
                wr_data <= '{handle: cur.handle, queued: 8'd0, in_flight: 8'd0,
                             parked: cur.parked};
                link_total <= link_total + CW'(1);
              end
            end
            CMD_LINK_DOWN: begin
              if (!have) rsp.status <= ST_NOT_FOUND;
              else begin
                outstanding <= (outstanding > best_e.in_flight) ?
                               outstanding - best_e.in_flight : 8'd0;
                if (best == last_sender) last_sender <= '0;
                else if (best < last_sender) last_sender <= last_sender - IW'(1);
                shift_i <= best;
                state   <= S_SHIFT;
                rvalid  <= 1'b0;
              end
            end
            CMD_ENQUEUE: begin
              if (!have) rsp.status <= ST_NOT_FOUND;
              else if (best_e.queued != 8'hFF) begin
                wr_en   <= 1'b1;
                wr_addr <= best;
                wr_data <= '{handle: best_e.handle, queued: best_e.queued + 8'd1,
                             in_flight: best_e.in_flight, parked: best_e.parked};
              end
            end
            CMD_COMPLETED: begin
              if (!have || best_e.in_flight == 8'd0) rsp.status <= ST_NOT_FOUND;
              else begin
                wr_en   <= 1'b1;
                wr_addr <= best;
                wr_data <= '{handle: best_e.handle, queued: best_e.queued,
                             in_flight: (best_e.in_flight > cur.count) ?
                                        best_e.in_flight - cur.count : 8'd0,
                             parked: best_e.parked};
                outstanding <= (outstanding > cur.count) ? outstanding - cur.count : 8'd0;
              end
            end
            CMD_SET_PARK: begin
              if (link_total < CW'(2)) rsp.status <= ST_NOT_ALLOW;
              else if (!have) rsp.status <= ST_NOT_FOUND;
              else begin
                wr_en   <= 1'b1;
                wr_addr <= best;
                wr_data <= '{handle: best_e.handle, queued: best_e.queued,
                             in_flight: best_e.in_flight, parked: cur.parked};
              end
            end
            CMD_ISSUE: begin
              if (link_total == '0) rsp.status <= ST_NO_LINKS;
              else begin
                // best_e holds the pick unless nothing was queued; then the
                // entry 0 read is in rd_data.
                automatic entry_t e = have ? best_e : rd_data;
                rsp.send_handle <= e.handle;
                if (free == 8'd0 || e.queued == 8'd0) rsp.status <= ST_NO_CREDIT;
                else if ((e.parked && e.handle != broadcast_handle) ||
                         !({1'b0, e.in_flight} + 9'd1 < {1'b0, controller_buffers}))
                  rsp.status <= ST_NOT_ALLOW;
                else begin
                  last_sender <= best;
                  if (!cur.link_accepts) rsp.status <= ST_REFUSED;
                  else begin
                    rsp.sent <= 1'b1;
                    wr_en    <= 1'b1;
                    wr_addr  <= best;
                    wr_data  <= '{handle: e.handle, queued: e.queued - 8'd1,
                                  in_flight: (e.in_flight != 8'hFF) ?
                                             e.in_flight + 8'd1 : e.in_flight,
                                  parked: e.parked};
                    if (outstanding != 8'hFF) outstanding <= outstanding + 8'd1;
                  end
                end
              end
            end
            default: rsp.status <= ST_NOT_ALLOW;
          endcase
        end
        S_SHIFT: begin
          // Compaction: read entry i+1, then write it to i.
          rvalid <= 1'b0;
          if (rvalid) begin
            wr_en   <= 1'b1;
            wr_addr <= shift_i;
            wr_data <= rd_data;
            shift_i <= shift_i + IW'(1);
          end else if (CW'(shift_i) + CW'(1) < link_total) begin
            rvalid <= 1'b1;
          end else begin
            link_total <= link_total - CW'(1);
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          rsp.credits <= free;
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
